/* sv/hvd_pkg.sv */
`timescale 1ns / 1ps
package hvd_pkg;

  localparam int ANGLE_WIDTH   = 32;
  localparam int DIST_WIDTH    = 29;
  localparam int CORDIC_STAGES = 28;

  // q30 angles always come out 33 bits wide whatever the input width
  localparam int Q30_W   = 33;
  localparam int DIFF_W  = 34;
  localparam int PROD_W  = 64;
  localparam int TRIG_W  = 34;
  localparam int ZW      = 34;
  localparam int VEC_W   = 35;
  localparam int SQ_W    = 64;
  localparam int SQRT_STEPS = 32;
  localparam int RADIUS_W   = 24;
  localparam int ZC_W       = 31;
  localparam int T_W        = ZC_W + RADIUS_W;
  localparam int M_W        = 66;
  localparam int D_W        = 32;
  localparam int SAT_W      = 41;

  localparam logic signed [31:0] TWO_OVER_PI = 32'sd683565276;
  localparam logic [29:0] CORDIC_GAIN = 30'd652032875;
  localparam logic [29:0] PI_Q28 = 30'd843314857;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd6371000;
  localparam logic [30:0] Q_ONE = 31'h4000_0000;

  localparam logic [31:0] ATAN_TURNS [40] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
  };

  typedef struct packed {
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] y;
    logic signed [ZW-1:0]     z;
    logic                     neg;
  } rot_t;

  typedef struct packed {
    logic [SQ_W-1:0] n;
    logic [SQ_W-1:0] res;
  } sqrt_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ZW-1:0]    z;
  } vec_t;

endpackage

/* sv/hvd_rot_cell.sv */
`timescale 1ns / 1ps
module hvd_rot_cell #(
  parameter int STAGE = 0
) (
  input  logic         clk,
  input  logic         en,
  input  hvd_pkg::rot_t d,
  output hvd_pkg::rot_t q
);

  localparam logic signed [hvd_pkg::ZW-1:0] ATAN = hvd_pkg::ZW'(hvd_pkg::ATAN_TURNS[STAGE]);

  hvd_pkg::rot_t q_next;
  logic signed [hvd_pkg::TRIG_W-1:0] xs;
  logic signed [hvd_pkg::TRIG_W-1:0] ys;

  always_comb begin
    xs = $signed(d.x) >>> STAGE;
    ys = $signed(d.y) >>> STAGE;
    q_next.neg = d.neg;
    if (!d.z[hvd_pkg::ZW-1]) begin
      q_next.x = d.x - ys;
      q_next.y = d.y + xs;
      q_next.z = d.z - ATAN;
    end else begin
      q_next.x = d.x + ys;
      q_next.y = d.y - xs;
      q_next.z = d.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

/* sv/hvd_sqrt_cell.sv */
`timescale 1ns / 1ps
module hvd_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           en,
  input  hvd_pkg::sqrt_t d,
  output hvd_pkg::sqrt_t q
);

  localparam logic [hvd_pkg::SQ_W-1:0] BIT = hvd_pkg::SQ_W'(1) << (62 - 2 * STEP);

  hvd_pkg::sqrt_t q_next;
  logic [hvd_pkg::SQ_W-1:0] trial;

  always_comb begin
    trial = d.res + BIT;
    if (d.n >= trial) begin
      q_next.n   = d.n - trial;
      q_next.res = (d.res >> 1) + BIT;
    end else begin
      q_next.n   = d.n;
      q_next.res = d.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

/* sv/hvd_vec_cell.sv */
`timescale 1ns / 1ps
module hvd_vec_cell #(
  parameter int STAGE = 0
) (
  input  logic          clk,
  input  logic          en,
  input  hvd_pkg::vec_t d,
  output hvd_pkg::vec_t q
);

  localparam logic signed [hvd_pkg::ZW-1:0] ATAN = hvd_pkg::ZW'(hvd_pkg::ATAN_TURNS[STAGE]);

  hvd_pkg::vec_t q_next;
  logic signed [hvd_pkg::VEC_W-1:0] xs;
  logic signed [hvd_pkg::VEC_W-1:0] ys;

  always_comb begin
    xs = $signed(d.x) >>> STAGE;
    ys = $signed(d.y) >>> STAGE;
    if ($signed(d.y) > 0) begin
      q_next.x = d.x + ys;
      q_next.y = d.y - xs;
      q_next.z = d.z + ATAN;
    end else begin
      q_next.x = d.x - ys;
      q_next.y = d.y + xs;
      q_next.z = d.z - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

/* sv/haversine_distance_core.sv */
`timescale 1ns / 1ps
// Great-circle distance of two points by the haversine formula, fully pipelined:
// one point pair is taken per cycle while the output is not stalled. The
// chain of cells holds CORDIC_STAGES rotation cells for the four sin/cos lanes,
// 32 square-root cells for sqrt(h) and sqrt(1-h), CORDIC_STAGES vectoring
// cells for atan2, plus eight product and scaling registers. A stall on the
// output freezes the whole chain. The user must write earth_radius only while
// no transaction is in flight; the block itself does not enforce it.
module haversine_distance_core #(
  parameter int ANGLE_WIDTH   = hvd_pkg::ANGLE_WIDTH,
  parameter int DIST_WIDTH    = hvd_pkg::DIST_WIDTH,
  parameter int CORDIC_STAGES = hvd_pkg::CORDIC_STAGES
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [ANGLE_WIDTH-1:0]        lat_a,
  input  logic signed [ANGLE_WIDTH-1:0]        lon_a,
  input  logic signed [ANGLE_WIDTH-1:0]        lat_b,
  input  logic signed [ANGLE_WIDTH-1:0]        lon_b,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [DIST_WIDTH-1:0]                distance,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [hvd_pkg::RADIUS_W-1:0]         earth_radius
);

  localparam int LAT = 2 * CORDIC_STAGES + hvd_pkg::SQRT_STEPS + 8;
  localparam int SQ_INIT = CORDIC_STAGES + 4;

  logic en;
  logic [LAT-1:0] vld;
  logic [hvd_pkg::RADIUS_W-1:0] radius;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[LAT-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= hvd_pkg::RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radius <= earth_radius;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // angles to q30
  logic signed [ANGLE_WIDTH-1:0] raw [4];
  logic signed [hvd_pkg::Q30_W-1:0] q30 [4];

  assign raw[0] = lat_a;
  assign raw[1] = lon_a;
  assign raw[2] = lat_b;
  assign raw[3] = lon_b;

  for (genvar k = 0; k < 4; k++) begin : g_q30
    if (ANGLE_WIDTH > hvd_pkg::Q30_W) begin : g_dn
      assign q30[k] = $signed(raw[k][ANGLE_WIDTH-1 -: hvd_pkg::Q30_W]);
    end else if (ANGLE_WIDTH == hvd_pkg::Q30_W) begin : g_eq
      assign q30[k] = raw[k];
    end else begin : g_up
      assign q30[k] = $signed({raw[k], {(hvd_pkg::Q30_W - ANGLE_WIDTH){1'b0}}});
    end
  end

  // lanes: half dlat, half dlon, lat_a, lat_b
  logic signed [hvd_pkg::DIFF_W-1:0] ang [4];
  logic signed [hvd_pkg::PROD_W-1:0] phase_prod [4];

  always_ff @(posedge clk) begin
    if (en) begin
      ang[0] <= hvd_pkg::DIFF_W'(q30[2]) - hvd_pkg::DIFF_W'(q30[0]);
      ang[1] <= hvd_pkg::DIFF_W'(q30[3]) - hvd_pkg::DIFF_W'(q30[1]);
      ang[2] <= hvd_pkg::DIFF_W'(q30[0]);
      ang[3] <= hvd_pkg::DIFF_W'(q30[2]);
      for (int k = 0; k < 4; k++) begin
        phase_prod[k] <= ang[k] * hvd_pkg::TWO_OVER_PI;
      end
    end
  end

  hvd_pkg::rot_t rot_c [4][CORDIC_STAGES+1];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    localparam int EXTRA = (l < 2) ? 1 : 0;
    logic [31:0] phase;
    logic [31:0] quarter;
    logic [31:0] folded;

    always_comb begin
      phase   = phase_prod[l][61 + EXTRA -: 32];
      quarter = phase + 32'h4000_0000;
      folded  = quarter[31] ? {~phase[31], phase[30:0]} : phase;
      rot_c[l][0].x   = hvd_pkg::TRIG_W'(hvd_pkg::CORDIC_GAIN);
      rot_c[l][0].y   = '0;
      rot_c[l][0].z   = hvd_pkg::ZW'($signed(folded));
      rot_c[l][0].neg = quarter[31];
    end

    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_rot
      hvd_rot_cell #(.STAGE(s)) u_cell (
        .clk (clk),
        .en  (en),
        .d   (rot_c[l][s]),
        .q   (rot_c[l][s+1])
      );
    end
  end

  // h = sin^2(dlat/2) + cos(lat_a) cos(lat_b) sin^2(dlon/2)
  logic signed [hvd_pkg::TRIG_W-1:0] s1, s2, ca, cb;
  logic signed [67:0] p_s1, p_s2, p_cc, p_h;
  logic signed [hvd_pkg::TRIG_W-1:0] sq1, sq2, cc, sq1_d, hb;
  logic signed [hvd_pkg::TRIG_W:0] h_sum;
  logic [hvd_pkg::ZC_W-1:0] h_clamp;

  always_comb begin
    s1 = rot_c[0][CORDIC_STAGES].neg ? -rot_c[0][CORDIC_STAGES].y : rot_c[0][CORDIC_STAGES].y;
    s2 = rot_c[1][CORDIC_STAGES].neg ? -rot_c[1][CORDIC_STAGES].y : rot_c[1][CORDIC_STAGES].y;
    ca = rot_c[2][CORDIC_STAGES].neg ? -rot_c[2][CORDIC_STAGES].x : rot_c[2][CORDIC_STAGES].x;
    cb = rot_c[3][CORDIC_STAGES].neg ? -rot_c[3][CORDIC_STAGES].x : rot_c[3][CORDIC_STAGES].x;
    p_s1 = s1 * s1;
    p_s2 = s2 * s2;
    p_cc = ca * cb;
    p_h  = cc * sq2;
    h_sum = (hvd_pkg::TRIG_W+1)'(sq1_d) + (hvd_pkg::TRIG_W+1)'(hb);
    if (h_sum < 0) begin
      h_clamp = '0;
    end else if (h_sum > $signed({4'b0, hvd_pkg::Q_ONE})) begin
      h_clamp = hvd_pkg::Q_ONE;
    end else begin
      h_clamp = h_sum[hvd_pkg::ZC_W-1:0];
    end
  end

  hvd_pkg::sqrt_t sq_c [2][hvd_pkg::SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sq1   <= p_s1[63:30];
      sq2   <= p_s2[63:30];
      cc    <= p_cc[63:30];
      sq1_d <= sq1;
      hb    <= p_h[63:30];
      sq_c[0][0].n   <= {3'b0, h_clamp, 30'b0};
      sq_c[0][0].res <= '0;
      sq_c[1][0].n   <= {3'b0, hvd_pkg::Q_ONE - h_clamp, 30'b0};
      sq_c[1][0].res <= '0;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_sq
    for (genvar s = 0; s < hvd_pkg::SQRT_STEPS; s++) begin : g_step
      hvd_sqrt_cell #(.STEP(s)) u_cell (
        .clk (clk),
        .en  (en),
        .d   (sq_c[l][s]),
        .q   (sq_c[l][s+1])
      );
    end
  end

  // atan2(sqrt(h), sqrt(1-h))
  hvd_pkg::vec_t vec_c [CORDIC_STAGES+1];

  always_comb begin
    vec_c[0].x = hvd_pkg::VEC_W'(sq_c[1][hvd_pkg::SQRT_STEPS].res[30:0]);
    vec_c[0].y = hvd_pkg::VEC_W'(sq_c[0][hvd_pkg::SQRT_STEPS].res[30:0]);
    vec_c[0].z = '0;
  end

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_vec
    hvd_vec_cell #(.STAGE(s)) u_cell (
      .clk (clk),
      .en  (en),
      .d   (vec_c[s]),
      .q   (vec_c[s+1])
    );
  end

  // scale by radius and pi/2^26, round, saturate
  logic signed [hvd_pkg::ZW-1:0] z_end;
  logic [hvd_pkg::ZC_W-1:0] z_clamp;
  logic [hvd_pkg::T_W-1:0] t;
  logic [hvd_pkg::M_W-1:0] m;
  logic [hvd_pkg::M_W-1:0] m_round;
  logic [hvd_pkg::SAT_W-1:0] d_ext;
  logic [hvd_pkg::SAT_W-1:0] d_max;

  always_comb begin
    z_end = vec_c[CORDIC_STAGES].z;
    if (z_end < 0) begin
      z_clamp = '0;
    end else if (z_end > $signed({3'b0, hvd_pkg::Q_ONE})) begin
      z_clamp = hvd_pkg::Q_ONE;
    end else begin
      z_clamp = z_end[hvd_pkg::ZC_W-1:0];
    end
    m_round = m + (hvd_pkg::M_W'(1) << 33);
    d_ext   = hvd_pkg::SAT_W'(m_round[hvd_pkg::M_W-1:34]);
    d_max   = (hvd_pkg::SAT_W'(1) << DIST_WIDTH) - hvd_pkg::SAT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t <= hvd_pkg::T_W'(z_clamp) * hvd_pkg::T_W'(radius);
      m <= hvd_pkg::M_W'(t[hvd_pkg::T_W-1:20]) * hvd_pkg::M_W'(hvd_pkg::PI_Q28);
      distance <= (d_ext > d_max) ? d_max[DIST_WIDTH-1:0] : d_ext[DIST_WIDTH-1:0];
    end
  end

  a_accept_enters : assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> vld[0])
    else $error("accepted transaction not entered in pipeline");

  a_stall_freezes : assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved while stalled");

  a_h_range : assert property (@(posedge clk) disable iff (rst)
    vld[SQ_INIT] |-> (sq_c[0][0].n <= (hvd_pkg::SQ_W'(1) << 60)))
    else $error("h outside unit range");

endmodule
